/* src/dhg_pkg.sv */
// ============================================================================
// dhg_pkg
// Shared widths, codes and control types of the diff hunk grouper.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dhg_pkg;

  localparam int IDX_W           = 24;
  localparam int LINE_IN_W       = 24;
  localparam int CTX_W           = 4;
  localparam int KIND_W          = 2;
  localparam int RUN_W           = 5;
  localparam int OFF_W           = 5;
  localparam int DEF_MAX_CONTEXT = 15;
  localparam int DEF_LINE_BITS   = 24;

  localparam logic [IDX_W-1:0]  IDX_MAX   = '1;
  localparam logic [RUN_W-1:0]  RUN_MAX   = '1;
  localparam logic [CTX_W-1:0]  CTX_RESET = 4'd3;

  localparam logic [KIND_W-1:0] KIND_COMMON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_TAKE,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic take;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic fin_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/diff_hunk_grouper.sv */
// An edit that needs no walk of the line store is accepted and then finished; the finish
// step of an edit that emits waits while the previous result is untaken. Walking the store
// adds a read and a take step per entry (one read port with registered data); opening a
// hunk walks up to context+1 entries and closing or resuming one walks the pending trailing
// commons. A result is in the output register the cycle after finish. One edit at a time.
// Reset: synchronous active-low rst_n clears all hunk state; ctx_r returns to 3.
// ============================================================================
// diff_hunk_grouper
// Groups the edit script of a finished diff into unified-diff hunks and
// reports index range, start lines and line counts per hunk.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module diff_hunk_grouper import dhg_pkg::*; #(
  parameter int MAX_CONTEXT = DEF_MAX_CONTEXT,
  parameter int LINE_BITS   = DEF_LINE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CTX_W-1:0]     cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KIND_W-1:0]    in_edit_kind,
  input  wire logic [LINE_IN_W-1:0] in_org_line,
  input  wire logic [LINE_IN_W-1:0] in_new_line,
  input  wire logic                 in_last_edit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [IDX_W-1:0]          out_begin_index,
  output logic [IDX_W-1:0]          out_end_index,
  output logic [IDX_W-1:0]          out_org_start,
  output logic [IDX_W-1:0]          out_org_count,
  output logic [IDX_W-1:0]          out_new_start,
  output logic [IDX_W-1:0]          out_new_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dhg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhg_dp #(
    .MAX_CONTEXT (MAX_CONTEXT),
    .LINE_BITS   (LINE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_edit_kind    (in_edit_kind),
    .in_org_line     (in_org_line),
    .in_new_line     (in_new_line),
    .in_last_edit    (in_last_edit),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_begin_index (out_begin_index),
    .out_end_index   (out_end_index),
    .out_org_start   (out_org_start),
    .out_org_count   (out_org_count),
    .out_new_start   (out_new_start),
    .out_new_count   (out_new_count),
    .cmd             (cmd),
    .stat            (stat)
  );

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the previous beat finished");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.fin))
    else $error("result raised without a finish step");

  a_take_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> $past(cmd.rd))
    else $error("line store data used without a preceding read");

endmodule

`default_nettype wire

/* src/dhg_ctrl.sv */
// ============================================================================
// dhg_ctrl
// Sequencer of the hunk grouper: accepts a beat, walks the line store and
// finishes the edit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dhg_ctrl import dhg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_scan ? S_READ : S_FIN;
        end
      end
      S_READ: begin
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        state_nxt = stat.scan_last ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (stat.fin_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: begin
        cmd.rd = 1'b1;
      end
      S_TAKE: begin
        cmd.take = 1'b1;
      end
      S_FIN: begin
        cmd.fin = stat.fin_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/dhg_dp.sv */
// ============================================================================
// dhg_dp
// Datapath of the hunk grouper: hunk state, line store, counters and the
// result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dhg_dp import dhg_pkg::*; #(
  parameter int MAX_CONTEXT = DEF_MAX_CONTEXT,
  parameter int LINE_BITS   = DEF_LINE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CTX_W-1:0]     cfg_wr_data,
  input  wire logic [KIND_W-1:0]    in_edit_kind,
  input  wire logic [LINE_IN_W-1:0] in_org_line,
  input  wire logic [LINE_IN_W-1:0] in_new_line,
  input  wire logic                 in_last_edit,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [IDX_W-1:0]          out_begin_index,
  output logic [IDX_W-1:0]          out_end_index,
  output logic [IDX_W-1:0]          out_org_start,
  output logic [IDX_W-1:0]          out_org_count,
  output logic [IDX_W-1:0]          out_new_start,
  output logic [IDX_W-1:0]          out_new_count,
  input  wire ctl_cmd_t             cmd,
  output dp_stat_t                  stat
);

  localparam int RING_DEPTH = MAX_CONTEXT + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_SIZE  = 1 << RING_AW;

  typedef logic [LINE_BITS-1:0] line_t;

  // Control and hunk state.
  logic [CTX_W-1:0]   ctx_r, ctx_nxt;
  logic [IDX_W-1:0]   edit_cnt_r, edit_cnt_nxt;
  logic [IDX_W-1:0]   scan_start_r, scan_start_nxt;
  logic               hunk_open_r, hunk_open_nxt;
  logic [IDX_W-1:0]   hunk_begin_r, hunk_begin_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [IDX_W-1:0]   org_n_r, org_n_nxt;
  logic [IDX_W-1:0]   new_n_r, new_n_nxt;
  line_t              org_s_r, org_s_nxt;
  line_t              new_s_r, new_s_nxt;
  logic               org_f_r, org_f_nxt;
  logic               new_f_r, new_f_nxt;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Line store.
  logic [2*LINE_BITS-1:0] ring [RING_SIZE];
  logic [2*LINE_BITS-1:0] rd_data_r;
  logic [RING_AW-1:0]     rd_addr;
  logic [31:0]            rd_addr_wide;

  // Item and plan registers.
  logic [KIND_W-1:0] kind_r;
  line_t             org_r;
  line_t             new_r;
  logic              last_r;
  logic              pre_r;
  logic              span_en_r;
  logic [OFF_W-1:0]  lo_r;
  logic [OFF_W-1:0]  off_r;
  logic              cur_en_r;
  logic              emit_r;
  logic [IDX_W-1:0]  end_r;

  // Result payload.
  logic [IDX_W-1:0] out_begin_r, out_end_r, out_org_s_r, out_org_n_r;
  logic [IDX_W-1:0] out_new_s_r, out_new_n_r;

  // Plan signals.
  logic [CTX_W-1:0] c_eff;
  logic [5:0]       c6, c2, run6, run6p;
  logic [RUN_W-1:0] run_p;
  logic             is_common, case_a, case_b, case_c, close_b;
  logic [IDX_W-1:0] top_a, begin_a, n_a;
  logic             far_a;
  logic [5:0]       n6;
  logic             p_pre, p_en, p_cur, p_emit, p_close;
  logic [5:0]       p_hi, p_lo;
  logic [IDX_W:0]   e1, e_close, e_sel;
  logic [IDX_W-1:0] end_sat;

  // Store read and finish values.
  logic             rd_ok;
  line_t            ring_org, ring_new;
  logic             org_hit, new_hit;
  line_t            org_s_aft, new_s_aft;
  logic             org_f_aft, new_f_aft;
  logic [IDX_W-1:0] org_n_aft, new_n_aft;

  assign c_eff = (32'(ctx_r) > 32'(MAX_CONTEXT)) ? CTX_W'(MAX_CONTEXT) : ctx_r;
  assign c6    = 6'(c_eff);
  assign c2    = {c6[4:0], 1'b0};
  assign run_p = (run_r == RUN_MAX) ? RUN_MAX : run_r + RUN_W'(1);
  assign run6  = 6'(run_r);
  assign run6p = 6'(run_p);

  assign is_common = (in_edit_kind == KIND_COMMON);
  assign case_a    = !hunk_open_r && !is_common;
  assign case_b    = hunk_open_r && is_common;
  assign case_c    = hunk_open_r && !is_common;
  assign close_b   = (run6p >= c2);

  assign top_a   = (scan_start_r > edit_cnt_r) ? edit_cnt_r : scan_start_r;
  assign far_a   = ({1'b0, edit_cnt_r} > ({1'b0, top_a} + (IDX_W+1)'(c_eff)));
  assign begin_a = far_a ? (edit_cnt_r - IDX_W'(c_eff)) : top_a;
  assign n_a     = edit_cnt_r - begin_a;
  assign n6      = n_a[5:0];

  always_comb begin
    p_pre   = 1'b0;
    p_en    = 1'b0;
    p_hi    = '0;
    p_lo    = 6'd1;
    p_cur   = 1'b0;
    p_emit  = 1'b0;
    p_close = 1'b0;
    if (case_a) begin
      p_pre  = (begin_a != '0);
      p_en   = (n6 != '0);
      p_hi   = n6;
      p_cur  = 1'b1;
      p_emit = in_last_edit;
    end else if (case_b) begin
      p_hi = run6p - c6 - 6'd1;
      if (close_b) begin
        p_en    = (c_eff == '0) ? (run6p >= 6'd2) : (run6p >= c2 + 6'd1);
        p_lo    = (c_eff == '0) ? 6'd1 : c6;
        p_cur   = (c_eff == '0);
        p_emit  = 1'b1;
        p_close = 1'b1;
      end else begin
        p_en   = in_last_edit && (run6p >= c6 + 6'd2);
        p_cur  = (run6p <= c6) || in_last_edit;
        p_emit = in_last_edit;
      end
    end else if (case_c) begin
      p_en   = (run6 >= c6 + 6'd1);
      p_hi   = run6 - c6;
      p_cur  = 1'b1;
      p_emit = in_last_edit;
    end
  end

  assign e1      = {1'b0, edit_cnt_r} + (IDX_W+1)'(1);
  assign e_close = e1 - (IDX_W+1)'(c_eff);
  assign e_sel   = p_close ? e_close : e1;
  assign end_sat = (e_sel > {1'b0, IDX_MAX}) ? IDX_MAX : e_sel[IDX_W-1:0];

  assign rd_addr_wide = 32'(wp_r) - 32'(off_r);
  assign rd_addr      = rd_addr_wide[RING_AW-1:0];

  assign rd_ok    = (IDX_W'(off_r) <= edit_cnt_r) && (32'(off_r) <= 32'(RING_DEPTH));
  assign ring_org = rd_ok ? rd_data_r[LINE_BITS-1:0] : '0;
  assign ring_new = rd_ok ? rd_data_r[2*LINE_BITS-1:LINE_BITS] : '0;

  assign org_hit   = cur_en_r && !org_f_r && (org_r != '0);
  assign new_hit   = cur_en_r && !new_f_r && (new_r != '0);
  assign org_s_aft = org_hit ? org_r : org_s_r;
  assign new_s_aft = new_hit ? new_r : new_s_r;
  assign org_f_aft = org_f_r || org_hit;
  assign new_f_aft = new_f_r || new_hit;
  assign org_n_aft = (cur_en_r && (kind_r != KIND_ADD) && (org_n_r != IDX_MAX)) ?
                     org_n_r + IDX_W'(1) : org_n_r;
  assign new_n_aft = (cur_en_r && (kind_r != KIND_DEL) && (new_n_r != IDX_MAX)) ?
                     new_n_r + IDX_W'(1) : new_n_r;

  assign stat.need_scan = p_pre || p_en;
  assign stat.scan_last = pre_r ? !span_en_r : (off_r == lo_r);
  assign stat.fin_ok    = !emit_r || !out_valid_r || out_ready;

  always_comb begin
    ctx_nxt        = cfg_wr_en ? cfg_wr_data : ctx_r;
    edit_cnt_nxt   = edit_cnt_r;
    scan_start_nxt = scan_start_r;
    hunk_open_nxt  = hunk_open_r;
    hunk_begin_nxt = hunk_begin_r;
    run_nxt        = run_r;
    org_n_nxt      = org_n_r;
    new_n_nxt      = new_n_r;
    org_s_nxt      = org_s_r;
    new_s_nxt      = new_s_r;
    org_f_nxt      = org_f_r;
    new_f_nxt      = new_f_r;
    wp_nxt         = wp_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.load) begin
      if (case_a) begin
        hunk_open_nxt  = 1'b1;
        hunk_begin_nxt = begin_a;
        run_nxt        = '0;
        org_n_nxt      = '0;
        new_n_nxt      = '0;
        org_s_nxt      = '0;
        new_s_nxt      = '0;
        org_f_nxt      = 1'b0;
        new_f_nxt      = 1'b0;
      end else if (case_b) begin
        run_nxt = run_p;
      end else if (case_c) begin
        run_nxt = '0;
      end
    end

    if (cmd.take) begin
      if (pre_r) begin
        org_s_nxt = ring_org;
        new_s_nxt = ring_new;
      end else begin
        if (!org_f_r && (ring_org != '0)) begin
          org_s_nxt = ring_org;
          org_f_nxt = 1'b1;
        end
        if (!new_f_r && (ring_new != '0)) begin
          new_s_nxt = ring_new;
          new_f_nxt = 1'b1;
        end
        if (org_n_r != IDX_MAX) begin
          org_n_nxt = org_n_r + IDX_W'(1);
        end
        if (new_n_r != IDX_MAX) begin
          new_n_nxt = new_n_r + IDX_W'(1);
        end
      end
    end

    if (cmd.fin) begin
      org_s_nxt    = org_s_aft;
      new_s_nxt    = new_s_aft;
      org_f_nxt    = org_f_aft;
      new_f_nxt    = new_f_aft;
      org_n_nxt    = org_n_aft;
      new_n_nxt    = new_n_aft;
      wp_nxt       = wp_r + RING_AW'(1);
      edit_cnt_nxt = (edit_cnt_r != IDX_MAX) ? edit_cnt_r + IDX_W'(1) : edit_cnt_r;
      if (emit_r || last_r) begin
        hunk_open_nxt  = 1'b0;
        hunk_begin_nxt = '0;
        run_nxt        = '0;
        org_n_nxt      = '0;
        new_n_nxt      = '0;
        org_s_nxt      = '0;
        new_s_nxt      = '0;
        org_f_nxt      = 1'b0;
        new_f_nxt      = 1'b0;
      end
      if (emit_r) begin
        out_valid_nxt  = 1'b1;
        scan_start_nxt = end_r;
      end
      if (last_r) begin
        edit_cnt_nxt   = '0;
        scan_start_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r        <= CTX_RESET;
      edit_cnt_r   <= '0;
      scan_start_r <= '0;
      hunk_open_r  <= 1'b0;
      hunk_begin_r <= '0;
      run_r        <= '0;
      org_n_r      <= '0;
      new_n_r      <= '0;
      org_s_r      <= '0;
      new_s_r      <= '0;
      org_f_r      <= 1'b0;
      new_f_r      <= 1'b0;
      wp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      ctx_r        <= ctx_nxt;
      edit_cnt_r   <= edit_cnt_nxt;
      scan_start_r <= scan_start_nxt;
      hunk_open_r  <= hunk_open_nxt;
      hunk_begin_r <= hunk_begin_nxt;
      run_r        <= run_nxt;
      org_n_r      <= org_n_nxt;
      new_n_r      <= new_n_nxt;
      org_s_r      <= org_s_nxt;
      new_s_r      <= new_s_nxt;
      org_f_r      <= org_f_nxt;
      new_f_r      <= new_f_nxt;
      wp_r         <= wp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      ring[wp_r] <= {new_r, org_r};
    end
    if (cmd.rd) begin
      rd_data_r <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_edit_kind;
      org_r     <= LINE_BITS'(in_org_line);
      new_r     <= LINE_BITS'(in_new_line);
      last_r    <= in_last_edit;
      pre_r     <= p_pre;
      span_en_r <= p_en;
      lo_r      <= OFF_W'(p_lo);
      off_r     <= p_pre ? OFF_W'(n6 + 6'd1) : OFF_W'(p_hi);
      cur_en_r  <= p_cur;
      emit_r    <= p_emit;
      end_r     <= end_sat;
    end else if (cmd.take) begin
      pre_r <= 1'b0;
      off_r <= off_r - OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && emit_r) begin
      out_begin_r <= hunk_begin_r;
      out_end_r   <= end_r;
      out_org_s_r <= IDX_W'(org_s_aft);
      out_org_n_r <= org_n_aft;
      out_new_s_r <= IDX_W'(new_s_aft);
      out_new_n_r <= new_n_aft;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_begin_index = out_begin_r;
  assign out_end_index   = out_end_r;
  assign out_org_start   = out_org_s_r;
  assign out_org_count   = out_org_n_r;
  assign out_new_start   = out_new_s_r;
  assign out_new_count   = out_new_n_r;

endmodule

`default_nettype wire
